>>> hdl/kht_pkg.sv
package kht_pkg;

  // Default sizes of the rectangle table and the coordinate space.
  localparam int MAX_KEYS_DEFAULT   = 64;
  localparam int COORD_BITS_DEFAULT = 16;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Fixed field widths of the words on the ports.
  localparam int INDEX_BITS = 6;
  localparam int FIELD_BITS = 16;
  localparam int COUNT_BITS = 7;

  // Command codes as they arrive on the input word.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Operation after classification in the front.
  typedef enum logic {
    OP_WRITE,
    OP_QUERY
  } op_t;

  // Back-end scan sequencer states.
  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } bk_state_t;

  // Input word as it arrives on the ports.
  typedef struct packed {
    logic                  command;
    logic [INDEX_BITS-1:0] key_index;
    logic [FIELD_BITS-1:0] key_left;
    logic [FIELD_BITS-1:0] key_top;
    logic [FIELD_BITS-1:0] key_width;
    logic [FIELD_BITS-1:0] key_height;
    logic [FIELD_BITS-1:0] point_x;
    logic [FIELD_BITS-1:0] point_y;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic                  hit;
    logic [INDEX_BITS-1:0] hit_index;
  } out_word_t;

  // Classified word held in the queue.
  typedef struct packed {
    op_t                   op;
    logic                  wr_ok;
    logic [INDEX_BITS-1:0] key_index;
    logic [FIELD_BITS-1:0] key_left;
    logic [FIELD_BITS-1:0] key_top;
    logic [FIELD_BITS-1:0] key_width;
    logic [FIELD_BITS-1:0] key_height;
    logic [FIELD_BITS-1:0] point_x;
    logic [FIELD_BITS-1:0] point_y;
  } q_entry_t;

  // Handshake between queue and back end.
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_out_t;

endpackage

>>> hdl/kht_front.sv
module kht_front #(
  parameter int MAX_KEYS = kht_pkg::MAX_KEYS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  kht_pkg::in_word_t item,
  output logic             busy,
  output kht_pkg::q_out_t  q_out,
  input  logic             pop
);
  import kht_pkg::*;

  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  q_entry_t         queue [QUEUE_DEPTH];
  logic [QPW-1:0]   wr_ptr;
  logic [QPW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;
  q_entry_t         cls;
  logic             push;
  logic             take;

  // Classify the incoming word: decode the operation and check the index range.
  always_comb begin
    cls.op         = (item.command == CMD_QUERY) ? OP_QUERY : OP_WRITE;
    cls.wr_ok      = (32'(item.key_index) < 32'(MAX_KEYS));
    cls.key_index  = item.key_index;
    cls.key_left   = item.key_left;
    cls.key_top    = item.key_top;
    cls.key_width  = item.key_width;
    cls.key_height = item.key_height;
    cls.point_x    = item.point_x;
    cls.point_y    = item.point_y;
  end

  // The front refuses words only when the queue is full.
  assign busy  = (count == QCW'(QUEUE_DEPTH));
  assign push  = start && !busy;
  assign take  = pop && (count != '0);

  assign q_out.valid = (count != '0);
  assign q_out.entry = queue[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cls;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPW'(1);
      end
      if (take) begin
        rd_ptr <= (rd_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPW'(1);
      end
      if (push && !take) begin
        count <= count + QCW'(1);
      end else if (take && !push) begin
        count <= count - QCW'(1);
      end
    end
  end

endmodule

>>> hdl/kht_back.sv
module kht_back #(
  parameter int MAX_KEYS   = kht_pkg::MAX_KEYS_DEFAULT,
  parameter int COORD_BITS = kht_pkg::COORD_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  kht_pkg::q_out_t                 q_out,
  input  logic [kht_pkg::COUNT_BITS-1:0]  key_count,
  output logic                            pop,
  output logic                            done,
  output kht_pkg::out_word_t              result
);
  import kht_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int NW = (CW > COUNT_BITS) ? CW : COUNT_BITS;
  localparam int EW = 4 * CB;

  logic [EW-1:0]   mem [MAX_KEYS];
  bk_state_t       state;
  bk_state_t       state_next;
  logic [CW-1:0]   rd_addr;
  logic [CW-1:0]   n_lim;
  logic [CW-1:0]   n_eff;
  logic [CW-1:0]   cmp_idx;
  logic            cmp_valid;
  logic [EW-1:0]   rd_data;
  logic [CB-1:0]   px;
  logic [CB-1:0]   py;
  logic [NW-1:0]   n_wide;
  logic [NW-1:0]   wa_ext;
  logic [NW-1:0]   idx_ext;
  logic [EW-1:0]   wr_data;
  logic            do_write;
  logic            scan_start;
  logic            issue;
  logic            emit;
  logic            emit_hit;
  logic            match;
  logic            last;

  // True when a lies in the inclusive span from origin to origin+len-1.
  function automatic logic span_holds(input logic [CB-1:0] a, input logic [CB-1:0] org,
                                      input logic [CB-1:0] len);
    span_holds = (len != '0) && (a >= org) && ((a - org) < len);
  endfunction

  // Effective scan length: the key count clipped to the table size.
  always_comb begin
    n_wide = (NW'(key_count) > NW'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(key_count);
    n_eff  = n_wide[CW-1:0];
  end

  assign wa_ext  = NW'(q_out.entry.key_index);
  assign idx_ext = NW'(cmp_idx);
  assign wr_data = {q_out.entry.key_left[CB-1:0], q_out.entry.key_top[CB-1:0],
                    q_out.entry.key_width[CB-1:0], q_out.entry.key_height[CB-1:0]};

  // Containment test on the entry read in the previous cycle.
  assign match = cmp_valid &&
                 span_holds(px, rd_data[EW-1 -: CB], rd_data[2*CB-1 -: CB]) &&
                 span_holds(py, rd_data[3*CB-1 -: CB], rd_data[CB-1:0]);
  assign last  = cmp_valid && (cmp_idx == n_lim - CW'(1));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_out.valid && (q_out.entry.op == OP_QUERY) && (n_eff != '0)) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (match || last) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    pop        = 1'b0;
    do_write   = 1'b0;
    scan_start = 1'b0;
    issue      = 1'b0;
    emit       = 1'b0;
    emit_hit   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (q_out.valid) begin
          pop = 1'b1;
          if (q_out.entry.op == OP_WRITE) begin
            do_write = q_out.entry.wr_ok;
            emit     = 1'b1;
          end else if (n_eff == '0) begin
            emit = 1'b1;
          end else begin
            scan_start = 1'b1;
          end
        end
      end
      BK_SCAN: begin
        issue = (rd_addr < n_lim) && !match && !last;
        if (match) begin
          emit     = 1'b1;
          emit_hit = 1'b1;
        end else if (last) begin
          emit = 1'b1;
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Rectangle table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wa_ext[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[rd_addr[AW-1:0]];
      cmp_idx <= rd_addr;
    end
  end

  // Query point and scan length, latched when a scan begins.
  always_ff @(posedge clk) begin
    if (scan_start) begin
      px    <= q_out.entry.point_x[CB-1:0];
      py    <= q_out.entry.point_y[CB-1:0];
      n_lim <= n_eff;
    end
  end

  // Sequencer state, scan address and compare-stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      rd_addr   <= '0;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= issue;
      if (scan_start) begin
        rd_addr <= '0;
      end else if (issue) begin
        rd_addr <= rd_addr + CW'(1);
      end
    end
  end

  // Result register: one strobe per word.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.hit       <= emit_hit;
      result.hit_index <= emit_hit ? idx_ext[INDEX_BITS-1:0] : '0;
    end
  end

endmodule

>>> hdl/key_rectangle_hit_test_core.sv
// Key rectangle hit test.
// Input channel: a word on item is taken at a clock edge with start high and
// busy low. A write word (command 0) stores one rectangle at key_index; a query
// word (command 1) searches entries 0 to min(key_count, MAX_KEYS)-1 for the
// lowest-index rectangle that holds (point_x, point_y), bounds inclusive.
// Output channel: every word gives one result, shown on result for one cycle
// with done high. Writes and misses give hit 0 and hit_index 0.
// Configuration: cfg_we writes cfg_data into key_count; zero makes all queries
// miss. Change it only while no word is in flight; the core does not enforce it.
// Timing: words pass a two-entry queue, then the back end. A query reads one
// table entry per cycle from the single read port of the table memory and
// checks it in the next cycle. busy rises only when the queue is full.
// Reset clears key_count, the queue and the sequencer; table contents are
// undefined until written. The receiver cannot stall; each result is taken in
// the cycle it is shown.
module key_rectangle_hit_test_core #(
  parameter int MAX_KEYS   = kht_pkg::MAX_KEYS_DEFAULT,
  parameter int COORD_BITS = kht_pkg::COORD_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  kht_pkg::in_word_t              item,
  output logic                           done,
  output kht_pkg::out_word_t             result,
  input  logic                           cfg_we,
  input  logic [kht_pkg::COUNT_BITS-1:0] cfg_data
);
  import kht_pkg::*;

  logic [COUNT_BITS-1:0] key_count;
  q_out_t                q_out;
  logic                  pop;

  // Key count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
    end else if (cfg_we) begin
      key_count <= cfg_data;
    end
  end

  // Front: accept and classify words into the queue.
  kht_front #(
    .MAX_KEYS(MAX_KEYS)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .item (item),
    .busy (busy),
    .q_out(q_out),
    .pop  (pop)
  );

  // Back: table writes and sequential scans.
  kht_back #(
    .MAX_KEYS  (MAX_KEYS),
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_out    (q_out),
    .key_count(key_count),
    .pop      (pop),
    .done     (done),
    .result   (result)
  );

  // A miss reports index zero.
  a_miss_index_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.hit) |-> (result.hit_index == '0))
    else $error("miss result with nonzero index");

  // A hit always lies below the key count.
  a_hit_below_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.hit) |-> (COUNT_BITS'(result.hit_index) < key_count))
    else $error("hit index beyond key count");

  // No result is shown right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe after reset");

  // The queue fills only through an accepted word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted word");

endmodule

>>> verif/key_rectangle_hit_test_core_tb.sv
`timescale 1ns / 1ps
module key_rectangle_hit_test_core_tb;
  import kht_pkg::*;

  localparam int TABLE_SIZE      = MAX_KEYS_DEFAULT;
  localparam int STALL_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int NUM_PHASES      = 10;
  localparam int COORD_MAX       = (1 << FIELD_BITS) - 1;

  // One row of the directed table; want is used only when typed is set.
  typedef struct {
    int        count;
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  in_word_t              item;
  logic                  done;
  out_word_t             result;
  logic                  cfg_we;
  logic [COUNT_BITS-1:0] cfg_data;

  // Shadow copy of the rectangle table and the key count.
  logic [FIELD_BITS-1:0] rect_left[TABLE_SIZE];
  logic [FIELD_BITS-1:0] rect_top[TABLE_SIZE];
  logic [FIELD_BITS-1:0] rect_width[TABLE_SIZE];
  logic [FIELD_BITS-1:0] rect_height[TABLE_SIZE];
  bit [TABLE_SIZE-1:0]   rect_written;
  logic [COUNT_BITS-1:0] key_count_model;

  out_word_t pending_hits[$];
  stim_row_t directed_rows[$];
  int        errors       = 0;
  int        stall_cycles = 0;
  int        idle_pct     = 27;

  key_rectangle_hit_test_core dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Inclusive span test; the difference cannot wrap since a >= origin is tested first.
  function automatic bit span_contains(int unsigned a, int unsigned origin, int unsigned len);
    return (len != 0) && (a >= origin) && ((a - origin) < len);
  endfunction

  // Applies one word to the shadow table and returns the search outcome.
  function automatic out_word_t hit_search(in_word_t w);
    out_word_t   r;
    int unsigned n;
    r = '0;
    if (w.command == CMD_WRITE) begin
      rect_left[w.key_index]    = w.key_left;
      rect_top[w.key_index]     = w.key_top;
      rect_width[w.key_index]   = w.key_width;
      rect_height[w.key_index]  = w.key_height;
      rect_written[w.key_index] = 1'b1;
    end else begin
      n = (key_count_model > TABLE_SIZE) ? TABLE_SIZE : key_count_model;
      for (int i = 0; i < n; i++) begin
        if (span_contains(w.point_x, rect_left[i], rect_width[i]) &&
            span_contains(w.point_y, rect_top[i], rect_height[i])) begin
          r.hit       = 1'b1;
          r.hit_index = INDEX_BITS'(i);
          break;
        end
      end
    end
    return r;
  endfunction

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  // Random write word; slot below zero picks a random table entry.
  function automatic in_word_t random_write(int slot);
    in_word_t    w;
    int unsigned shape;
    w           = '0;
    w.command   = CMD_WRITE;
    w.key_index = (slot < 0) ? INDEX_BITS'($urandom_range(TABLE_SIZE - 1)) : INDEX_BITS'(slot);
    w.point_x   = FIELD_BITS'($urandom);
    w.point_y   = FIELD_BITS'($urandom);
    shape = $urandom_range(99);
    if (shape < 70) begin
      // Small keys spread over the whole screen.
      w.key_left   = FIELD_BITS'($urandom);
      w.key_top    = FIELD_BITS'($urandom);
      w.key_width  = FIELD_BITS'($urandom_range(1, 64));
      w.key_height = FIELD_BITS'($urandom_range(1, 64));
    end else if (shape < 80) begin
      // Degenerate keys with one zero dimension.
      w.key_left   = FIELD_BITS'($urandom);
      w.key_top    = FIELD_BITS'($urandom);
      w.key_width  = FIELD_BITS'($urandom_range(1, 200));
      w.key_height = FIELD_BITS'($urandom_range(1, 200));
      if ($urandom_range(1)) w.key_width = '0;
      else w.key_height = '0;
    end else if (shape < 90) begin
      w.key_left   = FIELD_BITS'($urandom);
      w.key_top    = FIELD_BITS'($urandom);
      w.key_width  = FIELD_BITS'($urandom);
      w.key_height = FIELD_BITS'($urandom);
    end else begin
      // Keys that reach past the largest coordinate.
      w.key_left   = FIELD_BITS'(COORD_MAX - $urandom_range(31));
      w.key_top    = FIELD_BITS'(COORD_MAX - $urandom_range(31));
      w.key_width  = FIELD_BITS'(COORD_MAX - $urandom_range(3));
      w.key_height = FIELD_BITS'($urandom_range(1, 64));
    end
    return w;
  endfunction

  // Random query word, mostly aimed inside or at the edges of a scanned key.
  function automatic in_word_t random_query(int unsigned n);
    in_word_t    w;
    int          slot;
    int          x;
    int          y;
    int          wd;
    int          ht;
    int unsigned pick;
    w         = random_write(-1);
    w.command = CMD_QUERY;
    slot = (n == 0) ? $urandom_range(TABLE_SIZE - 1) : $urandom_range(n - 1);
    wd   = rect_width[slot];
    ht   = rect_height[slot];
    pick = $urandom_range(99);
    if (pick < 55) begin
      x = rect_left[slot] + ((wd == 0) ? 0 : ($urandom % wd));
      y = rect_top[slot] + ((ht == 0) ? 0 : ($urandom % ht));
    end else if (pick < 80) begin
      case ($urandom_range(3))
        0: x = rect_left[slot] - 1;
        1: x = rect_left[slot];
        2: x = rect_left[slot] + wd - 1;
        default: x = rect_left[slot] + wd;
      endcase
      case ($urandom_range(3))
        0: y = rect_top[slot] - 1;
        1: y = rect_top[slot];
        2: y = rect_top[slot] + ht - 1;
        default: y = rect_top[slot] + ht;
      endcase
    end else begin
      x = $urandom_range(COORD_MAX);
      y = $urandom_range(COORD_MAX);
    end
    w.point_x = FIELD_BITS'(clamp_coord(x));
    w.point_y = FIELD_BITS'(clamp_coord(y));
    return w;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic add_row(int count, logic cmd, int slot, int l, int t, int wd, int ht,
                         int x, int y, bit typed, logic hit, int hidx);
    stim_row_t r;
    r.count           = count;
    r.word.command    = cmd;
    r.word.key_index  = INDEX_BITS'(slot);
    r.word.key_left   = FIELD_BITS'(l);
    r.word.key_top    = FIELD_BITS'(t);
    r.word.key_width  = FIELD_BITS'(wd);
    r.word.key_height = FIELD_BITS'(ht);
    r.word.point_x    = FIELD_BITS'(x);
    r.word.point_y    = FIELD_BITS'(y);
    r.typed           = typed;
    r.want.hit        = hit;
    r.want.hit_index  = INDEX_BITS'(hidx);
    directed_rows.push_back(r);
  endtask

  // Offers one word, waits for it to be taken and records its expected result.
  task automatic send_word(in_word_t w, bit typed, out_word_t want);
    out_word_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= w;
    do @(posedge clk); while (busy);
    predicted = hit_search(w);
    pending_hits.push_back(typed ? want : predicted);
  endtask

  // Changes the key count only once every word in flight has finished.
  task automatic set_key_count(int v);
    start <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= COUNT_BITS'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    key_count_model = COUNT_BITS'(v);
  endtask

  // Stimulus: directed table, then random phases at several key counts.
  initial begin
    int          phase_counts[NUM_PHASES];
    int unsigned n_eff;
    int          lowest;
    in_word_t    w;
    phase_counts = '{64, 127, 1, 65, 0, -1, 64, -1, 2, 127};
    rst      = 1'b1;
    start    = 1'b0;
    item     = '0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    key_count_model = '0;
    rect_written    = '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      rect_left[i]   = '0;
      rect_top[i]    = '0;
      rect_width[i]  = '0;
      rect_height[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Key count zero: queries miss, writes fill entries 0 to 3 and 63.
    add_row(0, CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0);
    add_row(0, CMD_QUERY, 63, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 1, 0, 0);
    add_row(0, CMD_WRITE, 0, 100, 200, 10, 20, 0, 0, 1, 0, 0);
    add_row(0, CMD_WRITE, 1, 0, 0, 0, 500, 'hFFFF, 'hFFFF, 1, 0, 0);
    add_row(0, CMD_WRITE, 2, 0, 0, 300, 0, 0, 0, 1, 0, 0);
    add_row(0, CMD_WRITE, 3, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 0, 0, 1, 0, 0);
    add_row(0, CMD_WRITE, 63, 0, 0, 'hFFFF, 'hFFFF, 0, 0, 1, 0, 0);
    add_row(0, CMD_QUERY, 0, 0, 0, 0, 0, 105, 210, 1, 0, 0);
    // Four keys: inclusive corners, one past the left, right and bottom edges, zero-size keys.
    add_row(4, CMD_QUERY, 0, 0, 0, 0, 0, 100, 200, 1, 1, 0);
    add_row(4, CMD_QUERY, 0, 0, 0, 0, 0, 109, 219, 1, 1, 0);
    add_row(4, CMD_QUERY, 0, 0, 0, 0, 0, 110, 219, 0, 0, 0);
    add_row(4, CMD_QUERY, 0, 0, 0, 0, 0, 109, 220, 0, 0, 0);
    add_row(4, CMD_QUERY, 0, 0, 0, 0, 0, 99, 200, 0, 0, 0);
    add_row(4, CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(4, CMD_QUERY, 0, 0, 0, 0, 0, 'hFFFF, 'hFFFF, 1, 1, 3);
    add_row(4, CMD_QUERY, 0, 0, 0, 0, 0, 50, 0, 0, 0, 0);
    add_row(4, CMD_WRITE, 0, 0, 0, 1, 1, 0, 0, 1, 0, 0);
    add_row(4, CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0);
    add_row(4, CMD_QUERY, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].count != key_count_model) set_key_count(directed_rows[i].count);
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random phases; a query that would scan an unwritten entry becomes a write to it.
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_key_count((phase_counts[p] < 0) ? $urandom_range(127) : phase_counts[p]);
      idle_pct = (p == 6) ? 0 : 27;
      repeat (ITEMS_PER_PHASE) begin
        n_eff = (key_count_model > TABLE_SIZE) ? TABLE_SIZE : key_count_model;
        if ($urandom_range(99) < 35) begin
          w = random_write(-1);
        end else begin
          lowest = -1;
          for (int i = 0; i < n_eff; i++) begin
            if (!rect_written[i] && lowest < 0) lowest = i;
          end
          w = (lowest >= 0) ? random_write(lowest) : random_query(n_eff);
        end
        send_word(w, 1'b0, '0);
      end
    end

    // Drain and give stray results time to show up.
    start <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Each result word is checked against the oldest pending expectation.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && done) begin
      if (pending_hits.size() == 0) begin
        report_mismatch("result word with nothing pending", int'(result), 0);
      end else begin
        want = pending_hits.pop_front();
        if (result.hit !== want.hit) report_mismatch("hit", result.hit, want.hit);
        if (result.hit_index !== want.hit_index) begin
          report_mismatch("hit_index", result.hit_index, want.hit_index);
        end
      end
    end
  end

  // The run ends if neither side moves a word for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

>>> sim.f
hdl/kht_pkg.sv
hdl/kht_front.sv
hdl/kht_back.sv
hdl/key_rectangle_hit_test_core.sv
verif/key_rectangle_hit_test_core_tb.sv
